FILE: rtl/core/tpws_pkg.sv
// Shared types, constants and helpers for the track patch window selector.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package tpws_pkg;

   localparam int LAYER_COUNT_DEF = 5;
   localparam int ROW_DEPTH_DEF   = 64;

   localparam int OP_W     = 2;
   localparam int LAYER_W  = 3;
   localparam int HIT_W    = 32;
   localparam int START_W  = 6;
   localparam int RADIUS_W = 12;
   localparam int RADII_W  = 60;
   localparam int LIMIT_W  = 31;
   localparam int OFFSET_W = 16;
   localparam int PPL_W    = 6;
   localparam int SIZE_W   = 7;
   localparam int PROD_W   = 46;  // signed products feeding the divider
   localparam int MAG_W    = 45;  // dividend magnitude bits
   localparam int DIVR_W   = 13;  // signed divisor
   localparam int POS_W    = 48;  // projected z and trapezoid edge
   localparam int DIFF_W   = 49;  // distances between hit and target

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;
   localparam int REQ_DW = 104;
   localparam int RSP_DW = 80;

   localparam logic [2:0] REG_RADII      = 3'd0;
   localparam logic [2:0] REG_TOP_LIMIT  = 3'd1;
   localparam logic [2:0] REG_BEAM_LIMIT = 3'd2;
   localparam logic [2:0] REG_OFFSET     = 3'd3;
   localparam logic [2:0] REG_PPL        = 3'd4;
   localparam logic [2:0] REG_ALIGN      = 3'd5;
   localparam logic [2:0] REG_DOUBLE     = 3'd6;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_MAKE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [RADII_W-1:0]  radii;
      logic [LIMIT_W-1:0]  top_limit;
      logic [LIMIT_W-1:0]  beam_limit;
      logic [OFFSET_W-1:0] offset;
      logic [PPL_W-1:0]    ppl;
      logic                align;
      logic                dbl;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      radii:      60'd112611984944005200,
      top_limit:  31'd3276800,
      beam_limit: 31'd983040,
      offset:     16'd7,
      ppl:        6'd16,
      align:      1'b1,
      dbl:        1'b0
   };

   typedef struct packed {
      logic load;
      logic clear;
      logic make;
      logic proj_go;
      logic proj_take;
      logic edge_go;
      logic edge_take;
      logic scan_go;
      logic pick;
      logic mm_go;
      logic layer_store;
      logic layer_adv;
      logic decide;
      logic out_load;
      logic out_adv;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sweep_done;
      logic row_short;
      logic last_layer;
      logic out_last;
   } status_type;

   function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
      mag_of = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tpws_div.sv
// Serial signed divider with floor rounding, one quotient bit per cycle.
// Depends on tpws_pkg.
`default_nettype none

module tpws_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [tpws_pkg::PROD_W-1:0] dividend,
   input  logic signed [tpws_pkg::DIVR_W-1:0] divisor,
   output logic                               done,
   output logic signed [tpws_pkg::PROD_W-1:0] quotient
);
   import tpws_pkg::*;

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic                     busy_ff, fix_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [MAG_W-1:0]         num_ff;
   logic [DIVR_W-2:0]        den_ff;
   logic [DIVR_W-1:0]        rem_ff;
   logic signed [PROD_W-1:0] q_ff;
   logic [PROD_W-1:0]        dvd_mag;
   logic [DIVR_W-1:0]        dvr_mag;
   logic [DIVR_W-1:0]        trial;
   logic                     fits;
   logic [PROD_W-1:0]        q_raw;

   assign dvd_mag = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
   assign dvr_mag = divisor[DIVR_W-1] ? DIVR_W'(-divisor) : DIVR_W'(divisor);
   assign trial   = {rem_ff[DIVR_W-2:0], num_ff[MAG_W-1]};
   assign fits    = trial >= {1'b0, den_ff};
   assign q_raw   = PROD_W'(num_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= dvd_mag[MAG_W-1:0];
            den_ff  <= dvr_mag[DIVR_W-2:0];
            rem_ff  <= '0;
            neg_ff  <= dividend[PROD_W-1] ^ divisor[DIVR_W-1];
         end else if (busy_ff) begin
            rem_ff <= fits ? DIVR_W'(trial - {1'b0, den_ff}) : trial;
            num_ff <= {num_ff[MAG_W-2:0], fits};
            cnt_ff <= CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end else if (fix_ff) begin
            // round toward minus infinity on a negative quotient
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
            if (!neg_ff) q_ff <= $signed(q_raw);
            else if (rem_ff != '0) q_ff <= $signed(~q_raw);
            else q_ff <= $signed(PROD_W'(-q_raw));
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tpws_ctrl.sv
// Sequencer for loads, clears and patch building; drives datapath commands.
// Depends on tpws_pkg.
`default_nettype none

module tpws_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [tpws_pkg::OP_W-1:0]     req_op,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  tpws_pkg::status_type          status,
   output tpws_pkg::cmd_type             cmd
);
   import tpws_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_PROJ  = 12'b000000000010,
      S_PWAIT = 12'b000000000100,
      S_EWAIT = 12'b000000001000,
      S_CHECK = 12'b000000010000,
      S_SCAN  = 12'b000000100000,
      S_PICK  = 12'b000001000000,
      S_MMST  = 12'b000010000000,
      S_MM    = 12'b000100000000,
      S_NEXT  = 12'b001000000000,
      S_OUTLD = 12'b010000000000,
      S_EMIT  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (opcode_type'(req_op))
                  OP_LOAD:  cmd.load = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_MAKE: begin
                     cmd.make = 1'b1;
                     state_in = S_PROJ;
                  end
                  OP_NONE: ;
               endcase
            end
         end
         S_PROJ: begin
            cmd.proj_go = 1'b1;
            state_in    = S_PWAIT;
         end
         S_PWAIT: if (status.div_done) begin
            cmd.proj_take = 1'b1;
            cmd.edge_go   = 1'b1;
            state_in      = S_EWAIT;
         end
         S_EWAIT: if (status.div_done) begin
            cmd.edge_take = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (status.row_short) begin
               cmd.layer_store = 1'b1;
               state_in        = S_NEXT;
            end else begin
               cmd.scan_go = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: if (status.sweep_done) state_in = S_PICK;
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_MMST;
         end
         S_MMST: begin
            cmd.mm_go = 1'b1;
            state_in  = S_MM;
         end
         S_MM: if (status.sweep_done) begin
            cmd.layer_store = 1'b1;
            state_in        = S_NEXT;
         end
         S_NEXT: begin
            if (status.last_layer) begin
               cmd.decide = 1'b1;
               state_in   = S_OUTLD;
            end else begin
               cmd.layer_adv = 1'b1;
               state_in      = S_PROJ;
            end
         end
         S_OUTLD: begin
            cmd.out_load = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.out_last) state_in = S_IDLE;
               else cmd.out_adv = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/tpws_dp.sv
// Datapath: hit rows, projection, row sweeps, window pick and result registers.
// Depends on tpws_pkg and tpws_div.
`default_nettype none

module tpws_dp #(
   parameter int LAYER_COUNT = tpws_pkg::LAYER_COUNT_DEF,
   parameter int ROW_DEPTH   = tpws_pkg::ROW_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpws_pkg::cmd_type                   cmd,
   input  tpws_pkg::cfg_type                   cfg,
   input  logic [tpws_pkg::LAYER_W-1:0]        req_layer,
   input  logic signed [tpws_pkg::HIT_W-1:0]   req_hit,
   input  logic signed [tpws_pkg::HIT_W-1:0]   req_apex,
   input  logic signed [tpws_pkg::HIT_W-1:0]   req_top,
   output tpws_pkg::status_type                status,
   output logic [tpws_pkg::LAYER_W-1:0]        out_layer,
   output logic [tpws_pkg::START_W-1:0]        out_start,
   output logic signed [tpws_pkg::HIT_W-1:0]   out_min,
   output logic signed [tpws_pkg::HIT_W-1:0]   out_max,
   output logic                                out_status,
   output logic                                out_new,
   output logic                                out_last
);
   import tpws_pkg::*;

   localparam int LW       = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
   localparam int IW       = $clog2(ROW_DEPTH);
   localparam int CW       = $clog2(ROW_DEPTH + 1);
   localparam int SW       = CW + 3;
   localparam int MEM_DEPTH = LAYER_COUNT * (1 << IW);
   localparam int AW       = LW + IW;
   localparam logic [LW-1:0] LAST_LAYER = LW'(LAYER_COUNT - 1);
   localparam logic signed [SW-1:0] ONE  = SW'(1);
   localparam logic signed [SW-1:0] ZERO = '0;

   // hit rows and counts
   logic signed [HIT_W-1:0] row_mem [MEM_DEPTH];
   logic signed [HIT_W-1:0] rd_data_ff;
   logic [CW-1:0]           row_count_ff [LAYER_COUNT];
   logic [LW-1:0]           ld_sel;
   logic [CW-1:0]           ld_cnt;
   logic                    ld_ok;
   logic [AW-1:0]           wr_addr, rd_addr;

   // patch context
   logic [LW-1:0]           layer_ff;
   logic signed [HIT_W-1:0] apex_ff, top_ff;
   logic signed [POS_W-1:0] proj_ff, edge_ff;
   logic [RADIUS_W-1:0]     ri, r0, rmax;
   logic signed [HIT_W:0]   dt;
   logic signed [RADIUS_W:0] dr, dm;
   logic signed [HIT_W-1:0] lim_diff;
   logic signed [PROD_W-1:0] proj_prod, edge_prod;
   logic signed [PROD_W-1:0] div_q;
   logic                    div_done;
   logic [POS_W-1:0]        bl_off;
   logic [PPL_W-1:0]        ppl_eff;
   logic [SIZE_W-1:0]       size;
   logic [CW-1:0]           cnt_cur;
   logic                    mid, row_short;

   // sweep engine
   logic          sw_iss_ff, sw_mm_ff, pv_ff;
   logic [CW-1:0] sw_idx_ff, sw_end_ff, sw_first_ff, pj_ff;
   logic          first;
   logic signed [DIFF_W-1:0] d_near, d_left, d_right;

   // scan results
   logic [CW-1:0]            near_ff, lb_ff, rb_ff, s_ff;
   logic signed [DIFF_W-1:0] sval_ff;
   logic [DIFF_W-1:0]        lbv_ff, rbv_ff;
   logic signed [HIT_W-1:0]  mn_ff, mx_ff;

   // window pick
   logic signed [SW-1:0] p_st, p_rb, p_lb, p_cnt, p_sz, p_st1, p_s0, p_s1, p_s;

   // per-layer results and last accepted patch
   logic [START_W-1:0]      lay_start [LAYER_COUNT];
   logic signed [HIT_W-1:0] lay_min [LAYER_COUNT];
   logic signed [HIT_W-1:0] lay_max [LAYER_COUNT];
   logic                    lay_short [LAYER_COUNT];
   logic signed [HIT_W-1:0] prev_min_ff [LAYER_COUNT];
   logic signed [HIT_W-1:0] prev_max_ff [LAYER_COUNT];
   logic                    have_prev_ff, any_short_ff, diff_ff, accept_ff;
   logic signed [HIT_W-1:0] st_min, st_max;

   logic [LW-1:0] out_idx_ff, out_sel;
   logic          out_last_ff;

   assign ld_sel  = req_layer[LW-1:0];
   assign ld_cnt  = row_count_ff[ld_sel];
   assign ld_ok   = (req_layer < LAYER_W'(LAYER_COUNT)) && (ld_cnt < CW'(ROW_DEPTH));
   assign wr_addr = {ld_sel, ld_cnt[IW-1:0]};
   assign rd_addr = {layer_ff, sw_idx_ff[IW-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.load && ld_ok) row_mem[wr_addr] <= req_hit;
      rd_data_ff <= row_mem[rd_addr];
   end

   assign ri   = cfg.radii[RADIUS_W*layer_ff +: RADIUS_W];
   assign r0   = cfg.radii[RADIUS_W-1:0];
   assign rmax = cfg.radii[RADIUS_W*(LAYER_COUNT-1) +: RADIUS_W];

   assign dt        = (HIT_W+1)'(top_ff) - (HIT_W+1)'(apex_ff);
   assign dr        = $signed({1'b0, ri}) - $signed({1'b0, r0});
   assign dm        = $signed({1'b0, rmax}) - $signed({1'b0, r0});
   assign lim_diff  = $signed({1'b0, cfg.top_limit}) - $signed({1'b0, cfg.beam_limit});
   assign proj_prod = dt * dr;
   assign edge_prod = lim_diff * $signed({1'b0, ri});
   assign bl_off    = POS_W'(cfg.beam_limit) + POS_W'(cfg.offset);

   tpws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.proj_go | cmd.edge_go),
      .dividend (cmd.proj_go ? proj_prod : edge_prod),
      .divisor  (cmd.proj_go ? $signed(dm) : $signed({1'b0, rmax})),
      .done     (div_done),
      .quotient (div_q)
   );

   assign ppl_eff   = (cfg.ppl == '0) ? PPL_W'(1) : cfg.ppl;
   assign mid       = (layer_ff != '0) && (layer_ff != LAST_LAYER);
   assign size      = (cfg.dbl && mid) ? SIZE_W'({ppl_eff, 1'b0} - 1'b1) : SIZE_W'(ppl_eff);
   assign cnt_cur   = row_count_ff[layer_ff];
   assign row_short = SW'(cnt_cur) < SW'(size);

   assign first   = (pj_ff == sw_first_ff);
   assign d_near  = DIFF_W'(rd_data_ff) - DIFF_W'(proj_ff);
   assign d_left  = DIFF_W'(rd_data_ff) + DIFF_W'(edge_ff);
   assign d_right = DIFF_W'(rd_data_ff) - DIFF_W'(edge_ff);

   // window start: nudge, clamp to edge hit, clamp to row
   always_comb begin
      p_st  = $signed(SW'(near_ff));
      p_rb  = $signed(SW'(rb_ff));
      p_lb  = $signed(SW'(lb_ff));
      p_cnt = $signed(SW'(cnt_cur));
      p_sz  = $signed(SW'(size));
      if (cfg.align) begin
         p_st1 = (near_ff != '0 && sval_ff > 0) ? SW'(p_st - ONE) : p_st;
         p_s0  = (SW'(p_st1 + p_sz) > SW'(p_rb + ONE)) ? SW'(p_rb + ONE - p_sz) : p_st1;
      end else begin
         p_st1 = (p_st != SW'(p_cnt - ONE) && sval_ff < 0) ? SW'(p_st + ONE) : p_st;
         p_s0  = (SW'(p_st1 - p_sz + ONE) < p_lb) ? p_lb : SW'(p_st1 + ONE - p_sz);
      end
      p_s1 = (SW'(p_s0 + p_sz) > p_cnt) ? SW'(p_cnt - p_sz) : p_s0;
      p_s  = (p_s1 < ZERO) ? ZERO : p_s1;
   end

   assign st_min  = row_short ? '0 : mn_ff;
   assign st_max  = row_short ? '0 : mx_ff;
   assign out_sel = cmd.out_load ? '0 : LW'(out_idx_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAYER_COUNT; i++) begin
            row_count_ff[i] <= '0;
            prev_min_ff[i]  <= '0;
            prev_max_ff[i]  <= '0;
         end
         have_prev_ff <= 1'b0;
         sw_iss_ff    <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (cmd.load && ld_ok) row_count_ff[ld_sel] <= CW'(ld_cnt + 1'b1);
         if (cmd.clear) begin
            for (int i = 0; i < LAYER_COUNT; i++) row_count_ff[i] <= '0;
         end
         if (cmd.make) begin
            apex_ff      <= req_apex;
            top_ff       <= req_top;
            layer_ff     <= '0;
            any_short_ff <= 1'b0;
            diff_ff      <= 1'b0;
         end
         if (cmd.proj_take) begin
            proj_ff <= (rmax == r0) ? POS_W'(apex_ff) : POS_W'(POS_W'(apex_ff) + POS_W'(div_q));
         end
         if (cmd.edge_take) begin
            edge_ff <= (rmax == '0) ? $signed(bl_off) : $signed(POS_W'(POS_W'(div_q) + bl_off));
         end

         // issue row reads, one per cycle
         if (cmd.scan_go) begin
            sw_idx_ff   <= '0;
            sw_first_ff <= '0;
            sw_end_ff   <= cnt_cur;
            sw_mm_ff    <= 1'b0;
            sw_iss_ff   <= 1'b1;
         end else if (cmd.mm_go) begin
            sw_idx_ff   <= s_ff;
            sw_first_ff <= s_ff;
            sw_end_ff   <= CW'(s_ff + size);
            sw_mm_ff    <= 1'b1;
            sw_iss_ff   <= 1'b1;
         end else if (sw_iss_ff) begin
            sw_idx_ff <= CW'(sw_idx_ff + 1'b1);
            if (CW'(sw_idx_ff + 1'b1) == sw_end_ff) sw_iss_ff <= 1'b0;
         end
         pv_ff <= sw_iss_ff;
         pj_ff <= sw_idx_ff;

         // fold returning hits, earliest wins on ties
         if (pv_ff && !sw_mm_ff) begin
            if (first || mag_of(d_near) < mag_of(sval_ff)) begin
               near_ff <= pj_ff;
               sval_ff <= d_near;
            end
            if (first || mag_of(d_left) < lbv_ff) begin
               lb_ff  <= pj_ff;
               lbv_ff <= mag_of(d_left);
            end
            if (first || mag_of(d_right) < rbv_ff) begin
               rb_ff  <= pj_ff;
               rbv_ff <= mag_of(d_right);
            end
         end
         if (pv_ff && sw_mm_ff) begin
            if (first || rd_data_ff < mn_ff) mn_ff <= rd_data_ff;
            if (first || rd_data_ff > mx_ff) mx_ff <= rd_data_ff;
         end

         if (cmd.pick) s_ff <= p_s[CW-1:0];

         if (cmd.layer_store) begin
            lay_start[layer_ff] <= row_short ? '0 : s_ff[START_W-1:0];
            lay_min[layer_ff]   <= st_min;
            lay_max[layer_ff]   <= st_max;
            lay_short[layer_ff] <= row_short;
            any_short_ff        <= any_short_ff | row_short;
            diff_ff <= diff_ff | (st_min != prev_min_ff[layer_ff])
                               | (st_max != prev_max_ff[layer_ff]);
         end
         if (cmd.layer_adv) layer_ff <= LW'(layer_ff + 1'b1);

         if (cmd.decide) begin
            accept_ff <= !any_short_ff && (!have_prev_ff || diff_ff);
            if (!any_short_ff && (!have_prev_ff || diff_ff)) begin
               have_prev_ff <= 1'b1;
               for (int i = 0; i < LAYER_COUNT; i++) begin
                  prev_min_ff[i] <= lay_min[i];
                  prev_max_ff[i] <= lay_max[i];
               end
            end
         end

         if (cmd.out_load || cmd.out_adv) begin
            out_idx_ff  <= out_sel;
            out_last_ff <= (out_sel == LAST_LAYER);
            out_layer   <= LAYER_W'(out_sel);
            out_start   <= lay_start[out_sel];
            out_min     <= lay_min[out_sel];
            out_max     <= lay_max[out_sel];
            out_status  <= lay_short[out_sel];
         end
      end
   end

   assign out_new  = accept_ff;
   assign out_last = out_last_ff;

   assign status.div_done   = div_done;
   assign status.sweep_done = !sw_iss_ff && !pv_ff;
   assign status.row_short  = row_short;
   assign status.last_layer = (layer_ff == LAST_LAYER);
   assign status.out_last   = out_last_ff;

   a_pick_after_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> (!sw_iss_ff && !pv_ff))
      else $error("window pick while a row sweep is still running");

   a_load_no_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sw_iss_ff)
      else $error("row write while a row sweep is running");

   a_no_adv_past_last: assert property (@(posedge clock) disable iff (reset)
      cmd.out_adv |-> !out_last_ff)
      else $error("result advance past the final layer");

endmodule

`default_nettype wire

FILE: rtl/core/track_patch_window_select_top.sv
// Top level of the track patch window selector: register bank and wiring.
// Depends on tpws_pkg, tpws_ctrl, tpws_dp (and tpws_div below it).
`default_nettype none

// Channel   Direction  Signals                       Contents
// req_      in         tvalid/tready/tdata/tuser     load hit, make patch, clear rows
// rsp_      out        tvalid/tready/tdata/tuser/    one window per layer, tlast on
//                      tlast                         the final layer
// csr_      in/out     APB psel/penable/pwrite/...   seven registers at 8*index
//
// A load or clear is taken in the idle state and the next transfer can follow at once.
// A make patch holds req_tready low while the rows are walked: per layer the
// serial divider runs twice, for projection and edge, and the single read port
// of the hit memory sweeps the row and then the window (a short row skips
// both sweeps); then the first result is loaded and LAYER_COUNT result
// transfers follow.
// Reset clears the row counts and the last accepted patch; hit storage is not
// cleared. A stall on rsp_ holds the current result and blocks new requests.
module track_patch_window_select_top #(
   parameter int LAYER_COUNT = tpws_pkg::LAYER_COUNT_DEF,
   parameter int ROW_DEPTH   = tpws_pkg::ROW_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // layer_index[2:0], hit_z[34:3], apex_z[66:35], top_z[98:67], zero fill
   input  logic [tpws_pkg::REQ_DW-1:0]   req_tdata,
   // opcode[1:0]
   input  logic [tpws_pkg::OP_W-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_layer[2:0], window_start[8:3], window_min_z[40:9], window_max_z[72:41], zero fill
   output logic [tpws_pkg::RSP_DW-1:0]   rsp_tdata,
   // status[0], new_patch[1]
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tpws_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tpws_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tpws_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import tpws_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   logic [2:0] csr_idx;
   logic       csr_wr;

   logic [LAYER_W-1:0]      out_layer;
   logic [START_W-1:0]      out_start;
   logic signed [HIT_W-1:0] out_min, out_max;
   logic                    out_status, out_new;

   // register bank: written on the access phase of an APB write
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_RADII:      cfg_in.radii      = csr_pwdata[RADII_W-1:0];
            REG_TOP_LIMIT:  cfg_in.top_limit  = csr_pwdata[LIMIT_W-1:0];
            REG_BEAM_LIMIT: cfg_in.beam_limit = csr_pwdata[LIMIT_W-1:0];
            REG_OFFSET:     cfg_in.offset     = csr_pwdata[OFFSET_W-1:0];
            REG_PPL:        cfg_in.ppl        = csr_pwdata[PPL_W-1:0];
            REG_ALIGN:      cfg_in.align      = csr_pwdata[0];
            REG_DOUBLE:     cfg_in.dbl        = csr_pwdata[0];
            default: ;  // drop writes to unmapped addresses
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else cfg_ff <= cfg_in;
   end

   always_comb begin
      unique case (csr_idx)
         REG_RADII:      csr_prdata = CSR_DW'(cfg_ff.radii);
         REG_TOP_LIMIT:  csr_prdata = CSR_DW'(cfg_ff.top_limit);
         REG_BEAM_LIMIT: csr_prdata = CSR_DW'(cfg_ff.beam_limit);
         REG_OFFSET:     csr_prdata = CSR_DW'(cfg_ff.offset);
         REG_PPL:        csr_prdata = CSR_DW'(cfg_ff.ppl);
         REG_ALIGN:      csr_prdata = CSR_DW'(cfg_ff.align);
         REG_DOUBLE:     csr_prdata = CSR_DW'(cfg_ff.dbl);
         default:        csr_prdata = '0;
      endcase
   end

   tpws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tpws_dp #(
      .LAYER_COUNT (LAYER_COUNT),
      .ROW_DEPTH   (ROW_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .req_layer  (req_tdata[2:0]),
      .req_hit    ($signed(req_tdata[34:3])),
      .req_apex   ($signed(req_tdata[66:35])),
      .req_top    ($signed(req_tdata[98:67])),
      .status     (status),
      .out_layer  (out_layer),
      .out_start  (out_start),
      .out_min    (out_min),
      .out_max    (out_max),
      .out_status (out_status),
      .out_new    (out_new),
      .out_last   (rsp_tlast)
   );

   // pack the result transfer
   assign rsp_tdata = {7'b0, out_max, out_min, out_start, out_layer};
   assign rsp_tuser = {out_new, out_status};

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for track_patch_window_select_top: directed and random rows, patches and settings.
// Depends on tpws_pkg and the RTL below rtl/core; it reads no files.
`timescale 1ns / 1ps

module tb;
   import tpws_pkg::*;

   localparam int NL = LAYER_COUNT_DEF;
   localparam int RD = ROW_DEPTH_DEF;

   typedef struct {
      logic [2:0]         layer;
      logic [5:0]         start;
      logic signed [31:0] min_z;
      logic signed [31:0] max_z;
      logic               short_row;
      logic               new_patch;
      logic               last;
   } window_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic [OP_W-1:0]     req_tuser = OP_NONE;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Predictor copy of the block's settings and rows
   logic [59:0]         radii;
   longint              top_limit, beam_limit, edge_offset, ppl_reg;
   bit                  grow_right, double_mid;
   logic signed [31:0]  row_z [NL][RD];
   int                  row_len [NL];
   logic signed [31:0]  prev_bounds [2*NL];
   bit                  have_prev;

   window_t             window_q [$];
   int                  mismatches = 0;
   int                  n_loads = 0, n_makes = 0, n_windows = 0;
   int                  send_idle = 0, recv_idle = 0;
   int                  hold_cycles = 0;

   always #5 clock = ~clock;

   track_patch_window_select_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      if (b < 0) begin
         a = -a;
         b = -b;
      end
      q = a / b;
      if (a % b != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint abs_dist(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint radius(int i);
      return longint'(radii[12*i +: 12]);
   endfunction

   task automatic restore_defaults();
      radii       = CFG_RESET.radii;
      top_limit   = CFG_RESET.top_limit;
      beam_limit  = CFG_RESET.beam_limit;
      edge_offset = CFG_RESET.offset;
      ppl_reg     = CFG_RESET.ppl;
      grow_right  = CFG_RESET.align;
      double_mid  = CFG_RESET.dbl;
      foreach (row_len[i]) row_len[i] = 0;
      foreach (prev_bounds[i]) prev_bounds[i] = 0;
      have_prev = 0;
   endtask

   // Work out the five windows of one patch and queue them
   task automatic predict_patch(input logic signed [31:0] apex_in, input logic signed [31:0] top_in);
      longint apex, top, r0, rmax, ri, ppl, proj, edge_z, sz, s, cnt, z, d;
      longint st, sval, lb, lbv, rb, rbv;
      logic signed [31:0] bnd [2*NL];
      logic signed [31:0] mn, mx;
      int starts [NL];
      bit shrt [NL];
      bit any_short, accept;
      window_t w;
      apex = apex_in;
      top  = top_in;
      r0   = radius(0);
      rmax = radius(NL-1);
      ppl  = (ppl_reg == 0) ? 1 : ppl_reg;
      any_short = 0;
      accept = 0;
      for (int i = 0; i < NL; i++) begin
         ri  = radius(i);
         cnt = row_len[i];
         proj = (rmax == r0) ? apex : apex + floor_quot((top - apex) * (ri - r0), rmax - r0);
         edge_z = (rmax == 0) ? beam_limit + edge_offset
                : floor_quot(ri * (top_limit - beam_limit), rmax) + beam_limit + edge_offset;
         sz = (double_mid && i != 0 && i != NL-1) ? 2*ppl - 1 : ppl;
         if (cnt < sz) begin
            shrt[i] = 1;
            any_short = 1;
            starts[i] = 0;
            bnd[2*i] = 0;
            bnd[2*i+1] = 0;
            continue;
         end
         shrt[i] = 0;
         st = 0; sval = 0; lb = 0; lbv = 0; rb = 0; rbv = 0;
         for (longint j = 0; j < cnt; j++) begin
            z = row_z[i][j];
            d = z - proj;
            if (j == 0 || abs_dist(d) < abs_dist(sval)) begin
               st = j;
               sval = d;
            end
            if (j == 0 || abs_dist(z + edge_z) < lbv) begin
               lb = j;
               lbv = abs_dist(z + edge_z);
            end
            if (j == 0 || abs_dist(z - edge_z) < rbv) begin
               rb = j;
               rbv = abs_dist(z - edge_z);
            end
         end
         if (grow_right) begin
            if (st != 0 && sval >= 1) st--;
            s = (st + sz > rb + 1) ? rb + 1 - sz : st;
         end else begin
            if (st != cnt - 1 && sval <= -1) st++;
            s = (st - sz + 1 < lb) ? lb : st + 1 - sz;
         end
         if (s + sz > cnt) s = cnt - sz;
         if (s < 0) s = 0;
         mn = row_z[i][s];
         mx = row_z[i][s];
         for (longint j = s + 1; j < s + sz; j++) begin
            if (row_z[i][j] < mn) mn = row_z[i][j];
            if (row_z[i][j] > mx) mx = row_z[i][j];
         end
         starts[i] = int'(s);
         bnd[2*i] = mn;
         bnd[2*i+1] = mx;
      end
      if (!any_short) begin
         accept = !have_prev;
         foreach (bnd[k]) if (bnd[k] != prev_bounds[k]) accept = 1;
         if (accept) begin
            foreach (bnd[k]) prev_bounds[k] = bnd[k];
            have_prev = 1;
         end
      end
      for (int i = 0; i < NL; i++) begin
         w.layer     = 3'(i);
         w.start     = 6'(starts[i]);
         w.min_z     = bnd[2*i];
         w.max_z     = bnd[2*i+1];
         w.short_row = shrt[i];
         w.new_patch = accept;
         w.last      = (i == NL-1);
         window_q.insert(window_q.size(), w);
      end
   endtask

   // Offer one request, hold it until the transfer, then update the predictor
   task automatic send_item(input opcode_type op, input logic [2:0] layer,
                            input logic signed [31:0] hit, input logic signed [31:0] apex,
                            input logic signed [31:0] top);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {5'b0, top, apex, hit, layer};
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_LOAD: begin
            n_loads++;
            if (layer < NL && row_len[layer] < RD) begin
               row_z[layer][row_len[layer]] = hit;
               row_len[layer]++;
            end
         end
         OP_CLEAR: foreach (row_len[i]) row_len[i] = 0;
         OP_MAKE: begin
            n_makes++;
            predict_patch(apex, top);
         end
         default: ;
      endcase
   endtask

   task automatic load_hit(input int layer, input logic signed [31:0] hit);
      send_item(OP_LOAD, 3'(layer), hit, $urandom, $urandom);
   endtask

   task automatic make_patch(input logic signed [31:0] apex, input logic signed [31:0] top);
      send_item(OP_MAKE, 3'($urandom), $urandom, apex, top);
   endtask

   task automatic clear_rows();
      send_item(OP_CLEAR, 3'($urandom), $urandom, $urandom, $urandom);
   endtask

   // Wait until every window has come back, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (window_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         REG_RADII:      radii = val[59:0];
         REG_TOP_LIMIT:  top_limit = val[30:0];
         REG_BEAM_LIMIT: beam_limit = val[30:0];
         REG_OFFSET:     edge_offset = val[15:0];
         REG_PPL:        ppl_reg = val[5:0];
         REG_ALIGN:      grow_right = val[0];
         REG_DOUBLE:     double_mid = val[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [59:0] r, input longint tl, input longint bl,
                            input longint off, input longint ppl, input bit al, input bit dbl);
      csr_write(REG_RADII, 64'(r));
      csr_write(REG_TOP_LIMIT, 64'(tl));
      csr_write(REG_BEAM_LIMIT, 64'(bl));
      csr_write(REG_OFFSET, 64'(off));
      csr_write(REG_PPL, 64'(ppl));
      csr_write(REG_ALIGN, 64'(al));
      csr_write(REG_DOUBLE, 64'(dbl));
   endtask

   // Rows are empty after reset, so every layer comes back short
   task automatic test_empty_rows();
      make_patch(32'sd0, 32'sd0);
      drain();
   endtask

   // Extreme hit values, ignored loads, unused opcode, repeated patch
   task automatic test_extreme_hits();
      write_all(60'h0C8_0A0_078_050_028, 32'h7FFF_FFFF, 0, 16'hFFFF, 0, 1, 0);
      clear_rows();
      load_hit(0, 32'sh8000_0000);
      load_hit(0, -32'sd1);
      load_hit(0, 32'sd0);
      load_hit(0, 32'sd1);
      load_hit(0, 32'sh7FFF_FFFF);
      load_hit(1, 32'shAAAA_AAAA);
      load_hit(2, 32'sh5555_5555);
      load_hit(3, 32'sd0);
      load_hit(4, 32'sh7FFF_FFFF);
      load_hit(5, 32'sd3);
      load_hit(7, 32'sd3);
      send_item(OP_NONE, 3'd0, 32'sd3, 32'sd0, 32'sd0);
      make_patch(32'sh8000_0000, 32'sh7FFF_FFFF);
      make_patch(32'sd0, 32'sd0);
      make_patch(32'sd0, 32'sd0);
      make_patch(32'sh7FFF_FFFF, 32'sh8000_0000);
      drain();
      csr_write(REG_ALIGN, 0);
      make_patch(-32'sd1, 32'sd1);
      drain();
   endtask

   // Overfill one row and use the widest window
   task automatic test_full_row();
      write_all(CFG_RESET.radii, CFG_RESET.top_limit, CFG_RESET.beam_limit,
                CFG_RESET.offset, 32, 1, 1);
      clear_rows();
      for (int j = 0; j < RD + 2; j++) load_hit(0, 32'(j * 40000 - 1_300_000));
      make_patch(32'sd100_000, -32'sd200_000);
      drain();
      csr_write(REG_DOUBLE, 0);
      make_patch(32'sd100_000, -32'sd200_000);
      drain();
   endtask

   task automatic random_config(input int k);
      logic [59:0] r;
      int rv [NL];
      longint tl, bl;
      case (k % 5)
         0: r = '0;
         1: r = '1;
         default: begin
            foreach (rv[i]) rv[i] = $urandom_range(4095);
            rv.sort();
            foreach (rv[i]) r[12*i +: 12] = 12'(rv[i]);
         end
      endcase
      case ($urandom_range(3))
         0: begin tl = 0; bl = 0; end
         1: begin tl = 32'h7FFF_FFFF; bl = 32'h7FFF_FFFF; end
         default: begin
            tl = $urandom_range(32'h0040_0000);
            bl = $urandom_range(32'h0020_0000);
         end
      endcase
      write_all(r, tl, bl, $urandom_range(2) == 0 ? 16'hFFFF : $urandom_range(16'hFFFF),
                $urandom_range(6), $urandom_range(1), $urandom_range(1));
   endtask

   // Sorted rows with random content, then a few patches over them
   task automatic random_patches(input int first_seq, input int n_seq);
      longint z, stp;
      int size, cnt;
      bit wide;
      logic signed [31:0] apex, top;
      for (int k = first_seq; k < first_seq + n_seq; k++) begin
         random_config(k);
         clear_rows();
         wide = ($urandom_range(4) == 0);
         for (int i = 0; i < NL; i++) begin
            size = (ppl_reg == 0) ? 1 : int'(ppl_reg);
            if (double_mid && i != 0 && i != NL-1) size = 2*size - 1;
            cnt = ($urandom_range(9) == 0) ? $urandom_range(size) : size + $urandom_range(4);
            z = wide ? -longint'(32'h7FFF_FFFF) + $urandom_range(32'h0FFF_FFFF)
                     : $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            for (int j = 0; j < cnt; j++) begin
               stp = wide ? $urandom_range(32'h1FFF_FFFF) : $urandom_range(32'h0002_0000);
               if ($urandom_range(7) == 0) stp = 0;
               z = z + stp;
               if (z > 32'sh7FFF_FFFF) z = 32'sh7FFF_FFFF;
               load_hit(i, 32'(z));
               if ($urandom_range(19) == 0)
                  send_item(OP_NONE, 3'($urandom), $urandom, $urandom, $urandom);
               if ($urandom_range(19) == 0) load_hit($urandom_range(7, 5), $urandom);
            end
         end
         for (int m = 0; m < 2 + $urandom_range(1); m++) begin
            if (m == 0 || $urandom_range(2) != 0) begin
               apex = wide ? $urandom : $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
               top  = wide ? $urandom : $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            end
            make_patch(apex, top);
         end
         drain();
      end
   endtask

   // Receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle);
      end
   end

   // Compare every window transfer with the oldest prediction
   always @(posedge clock) begin
      window_t w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_windows++;
         if (window_q.size() == 0) begin
            $error("window transfer with no prediction waiting");
            mismatches++;
         end else begin
            w = window_q.pop_front();
            if (rsp_tdata[2:0] !== w.layer) begin
               $error("out_layer exp %0d got %0d", w.layer, rsp_tdata[2:0]);
               mismatches++;
            end
            if (rsp_tdata[8:3] !== w.start) begin
               $error("window_start exp %0d got %0d", w.start, rsp_tdata[8:3]);
               mismatches++;
            end
            if (rsp_tdata[40:9] !== w.min_z) begin
               $error("window_min_z exp %h got %h", w.min_z, rsp_tdata[40:9]);
               mismatches++;
            end
            if (rsp_tdata[72:41] !== w.max_z) begin
               $error("window_max_z exp %h got %h", w.max_z, rsp_tdata[72:41]);
               mismatches++;
            end
            if (rsp_tuser[0] !== w.short_row) begin
               $error("status exp %0d got %0d", w.short_row, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== w.new_patch) begin
               $error("new_patch exp %0d got %0d", w.new_patch, rsp_tuser[1]);
               mismatches++;
            end
            if (rsp_tlast !== w.last) begin
               $error("last exp %0d got %0d", w.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL track_patch_window_select_top");
      $finish;
   end

   initial begin
      restore_defaults();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_empty_rows();
      test_extreme_hits();
      test_full_row();

      // Sender barely idles while the receiver stalls often, then the reverse
      send_idle = 16;
      recv_idle = 70;
      random_patches(0, 1);
      send_idle = 70;
      recv_idle = 16;
      random_patches(1, 1);

      // No idling; hold the receiver off so results back up into the input
      send_idle = 0;
      recv_idle = 0;
      hold_cycles = 3000;
      random_patches(2, 2);

      drain();
      $display("Covered %0d loads and %0d patches, %0d windows checked,",
               n_loads, n_makes, n_windows);
      $display("across edge radii, limits, window sizes and both growth directions.");
      if (mismatches == 0 && window_q.size() == 0) begin
         $display("PASS track_patch_window_select_top");
      end else begin
         $display("FAIL track_patch_window_select_top");
      end
      $finish;
   end

endmodule
